// ===== rtl/core/card_point_to_world_transform_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Card point transform: assertion macros
// Shared wrappers for the concurrent checks of the transform unit.
// ----------------------------------------------------------------------------
`ifndef CARD_POINT_TO_WORLD_TRANSFORM_UNIT_DEFINES_SVH
`define CARD_POINT_TO_WORLD_TRANSFORM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define CPTW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define CPTW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cptw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card point transform package
// Payload types, register codes and fixed constants of the transform unit.
// ----------------------------------------------------------------------------
package cptw_pkg;

    localparam int DATA_W    = 32;
    localparam int ANGLE_W   = 16;
    localparam int IDX_W     = 3;
    localparam int ANG_W     = 36;   // Q6.30 angle accumulator
    localparam int CORDIC_W  = 34;   // Q4.30 rotator x/y
    localparam int ANG_SHIFT = 18;   // Q3.12 -> Q2.30
    localparam int ATAN_IDX_W = 5;   // 24-row arctangent table
    localparam int PIPE_LAT  = 11;   // request accept to result strobe

    localparam logic signed [ANG_W-1:0]    ANG_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0]    ANG_TWO_PI  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0]    ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [DATA_W-1:0] SCALE_RESET = 32'sd65536;
    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_SCALE_X = 3'd0,
        REG_SCALE_Y = 3'd1,
        REG_SHEAR_X = 3'd2,
        REG_SHEAR_Y = 3'd3,
        REG_ROLL    = 3'd4,
        REG_PITCH   = 3'd5,
        REG_YAW     = 3'd6
    } t_reg_idx;

    // Angle slot being refreshed by the rotator
    typedef enum logic [1:0] {
        ANG_ROLL  = 2'd0,
        ANG_PITCH = 2'd1,
        ANG_YAW   = 2'd2
    } t_ang_sel;

    typedef struct packed {
        logic signed [DATA_W-1:0] local_x;
        logic signed [DATA_W-1:0] local_y;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] world_x;
        logic signed [DATA_W-1:0] world_y;
        logic signed [DATA_W-1:0] world_z;
    } t_rsp;

    typedef struct packed {
        logic signed [DATA_W-1:0] scale_x;
        logic signed [DATA_W-1:0] scale_y;
        logic signed [DATA_W-1:0] shear_x;
        logic signed [DATA_W-1:0] shear_y;
    } t_geom;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_sts;

    // arctan(2^-i) in Q2.30
    function automatic logic [31:0] f_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd843314857;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043837;
            5'd3:    v = 32'd133525159;
            5'd4:    v = 32'd67021687;
            5'd5:    v = 32'd33543516;
            5'd6:    v = 32'd16775851;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194283;
            5'd9:    v = 32'd2097149;
            5'd10:   v = 32'd1048576;
            5'd11:   v = 32'd524288;
            5'd12:   v = 32'd262144;
            5'd13:   v = 32'd131072;
            5'd14:   v = 32'd65536;
            5'd15:   v = 32'd32768;
            5'd16:   v = 32'd16384;
            5'd17:   v = 32'd8192;
            5'd18:   v = 32'd4096;
            5'd19:   v = 32'd2048;
            5'd20:   v = 32'd1024;
            5'd21:   v = 32'd512;
            5'd22:   v = 32'd256;
            5'd23:   v = 32'd128;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/card_point_to_world_transform_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card point to world transform unit
// Maps a local 2D card point to a 3D world point: scale, shear, roll, pitch,
// yaw, in saturating Q16.16. Angle writes refresh sine/cosine by CORDIC.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------
//  request   | in        | start & !busy          | i_cmd (local_x, local_y)
//  result    | out       | o_valid, one cycle     | o_rsp (world_x/y/z)
//  config    | in        | i_cfg_we               | i_cfg_idx, i_cfg_wdata
//
//  One request per cycle while busy is low; results come back in request order.
//  An angle write holds busy from the write cycle on while the rotator
//  iterates; writes to several angles queue and run one after the other.
//  Reset loads exact unit cosines and zero sines, no rotator run.
//  The result side has no back-pressure, so the point pipeline never stalls.
// ----------------------------------------------------------------------------
`include "card_point_to_world_transform_unit_defines.svh"

module card_point_to_world_transform_unit
    import cptw_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_cmd              i_cmd,
    output logic              o_valid,
    output t_rsp              o_rsp,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_wdata
);

    localparam int TRIG_W = FRAC_BITS + 2;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) <<< FRAC_BITS;

    t_geom                    r_geom;
    logic signed [ANGLE_W-1:0] r_roll_angle, r_pitch_angle, r_yaw_angle;
    logic signed [TRIG_W-1:0] r_roll_cos, r_roll_sin;
    logic signed [TRIG_W-1:0] r_pitch_cos, r_pitch_sin;
    logic signed [TRIG_W-1:0] r_yaw_cos, r_yaw_sin;
    logic [2:0]               r_pend, n_pend;
    t_ang_sel                 r_sel, n_sel;

    logic                     ang_wr;
    logic                     cd_start;
    logic signed [ANGLE_W-1:0] cd_angle;
    t_cordic_sts              cd_sts;
    logic signed [TRIG_W-1:0] cd_cos, cd_sin;
    logic                     accept;

    assign ang_wr = i_cfg_we && ((t_reg_idx'(i_cfg_idx) == REG_ROLL)
                               || (t_reg_idx'(i_cfg_idx) == REG_PITCH)
                               || (t_reg_idx'(i_cfg_idx) == REG_YAW));
    assign busy   = (|r_pend) || cd_sts.busy || ang_wr;
    assign accept = start && !busy;

    // Pick the next queued angle, roll first
    always_comb begin
        n_sel    = r_sel;
        cd_start = 1'b0;
        if (!cd_sts.busy) begin
            if (r_pend[ANG_ROLL]) begin
                n_sel    = ANG_ROLL;
                cd_start = 1'b1;
            end else if (r_pend[ANG_PITCH]) begin
                n_sel    = ANG_PITCH;
                cd_start = 1'b1;
            end else if (r_pend[ANG_YAW]) begin
                n_sel    = ANG_YAW;
                cd_start = 1'b1;
            end
        end
        case (n_sel)
            ANG_ROLL:  cd_angle = r_roll_angle;
            ANG_PITCH: cd_angle = r_pitch_angle;
            ANG_YAW:   cd_angle = r_yaw_angle;
            default:   cd_angle = r_roll_angle;
        endcase
    end

    // Pending refresh bits: a new write wins over the clear at launch
    always_comb begin
        n_pend = r_pend;
        if (cd_start)
            n_pend[n_sel] = 1'b0;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ROLL:  n_pend[ANG_ROLL]  = 1'b1;
                REG_PITCH: n_pend[ANG_PITCH] = 1'b1;
                REG_YAW:   n_pend[ANG_YAW]   = 1'b1;
                default:   n_pend = n_pend;
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.scale_x <= SCALE_RESET;
            r_geom.scale_y <= SCALE_RESET;
            r_geom.shear_x <= '0;
            r_geom.shear_y <= '0;
            r_roll_angle   <= '0;
            r_pitch_angle  <= '0;
            r_yaw_angle    <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SCALE_X: r_geom.scale_x <= i_cfg_wdata;
                REG_SCALE_Y: r_geom.scale_y <= i_cfg_wdata;
                REG_SHEAR_X: r_geom.shear_x <= i_cfg_wdata;
                REG_SHEAR_Y: r_geom.shear_y <= i_cfg_wdata;
                REG_ROLL:    r_roll_angle   <= i_cfg_wdata[ANGLE_W-1:0];
                REG_PITCH:   r_pitch_angle  <= i_cfg_wdata[ANGLE_W-1:0];
                REG_YAW:     r_yaw_angle    <= i_cfg_wdata[ANGLE_W-1:0];
                default:     r_geom         <= r_geom;
            endcase
        end
    end

    // Refresh queue and trig state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_sel       <= ANG_ROLL;
            r_roll_cos  <= TRIG_ONE;
            r_roll_sin  <= '0;
            r_pitch_cos <= TRIG_ONE;
            r_pitch_sin <= '0;
            r_yaw_cos   <= TRIG_ONE;
            r_yaw_sin   <= '0;
        end else begin
            r_pend <= n_pend;
            r_sel  <= n_sel;
            if (cd_sts.done) begin
                case (r_sel)
                    ANG_ROLL: begin
                        r_roll_cos <= cd_cos;
                        r_roll_sin <= cd_sin;
                    end
                    ANG_PITCH: begin
                        r_pitch_cos <= cd_cos;
                        r_pitch_sin <= cd_sin;
                    end
                    ANG_YAW: begin
                        r_yaw_cos <= cd_cos;
                        r_yaw_sin <= cd_sin;
                    end
                    default: begin
                        r_roll_cos <= r_roll_cos;
                    end
                endcase
            end
        end
    end

    cptw_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_angle (cd_angle),
        .o_sts   (cd_sts),
        .o_cos   (cd_cos),
        .o_sin   (cd_sin)
    );

    cptw_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_cmd       (i_cmd),
        .i_geom      (r_geom),
        .i_roll_cos  (r_roll_cos),
        .i_roll_sin  (r_roll_sin),
        .i_pitch_cos (r_pitch_cos),
        .i_pitch_sin (r_pitch_sin),
        .i_yaw_cos   (r_yaw_cos),
        .i_yaw_sin   (r_yaw_sin),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

    `CPTW_ASSERT_IMP(a_rsp_has_req, i_clk, i_rst_n, o_valid, $past(accept, PIPE_LAT), "result without a matching request")
    `CPTW_ASSERT_IMP(a_pend_busy, i_clk, i_rst_n, (|r_pend) || cd_sts.busy, busy && !accept, "request accepted during trig refresh")
    `CPTW_ASSERT_IMP(a_trig_range, i_clk, i_rst_n, cd_sts.done, (cd_cos <= TRIG_ONE) && (cd_cos >= -TRIG_ONE) && (cd_sin <= TRIG_ONE) && (cd_sin >= -TRIG_ONE), "trig value beyond unit range")

endmodule

// ===== rtl/core/cptw_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card point transform: sine/cosine rotator
// Iterative CORDIC, one micro-rotation per cycle, with range reduction and
// rounding to Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
`include "card_point_to_world_transform_unit_defines.svh"

module cptw_cordic
    import cptw_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [ANGLE_W-1:0]   i_angle,
    output t_cordic_sts                 o_sts,
    output logic signed [FRAC_BITS+1:0] o_cos,
    output logic signed [FRAC_BITS+1:0] o_sin
);

    localparam int TRIG_W = FRAC_BITS + 2;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic signed [CORDIC_W-1:0] RND = 34'sd1 <<< (29 - FRAC_BITS);
    localparam logic signed [CORDIC_W-1:0] ONE = 34'sd1 <<< FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WRAP = 5'b00010,
        S_FOLD = 5'b00100,
        S_ROT  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                      r_state;
    logic [STEP_W-1:0]           r_step;
    logic signed [ANG_W-1:0]     r_z;
    logic signed [CORDIC_W-1:0]  r_x;
    logic signed [CORDIC_W-1:0]  r_y;
    logic                        r_flip;

    logic signed [CORDIC_W-1:0]  sh_x;
    logic signed [CORDIC_W-1:0]  sh_y;
    logic signed [ANG_W-1:0]     atan_v;
    logic signed [CORDIC_W-1:0]  c_rnd;
    logic signed [CORDIC_W-1:0]  s_rnd;
    logic signed [CORDIC_W-1:0]  c_clp;
    logic signed [CORDIC_W-1:0]  s_clp;

    // Micro-rotation operands
    always_comb begin
        sh_x   = r_x >>> r_step;
        sh_y   = r_y >>> r_step;
        atan_v = signed'(ANG_W'(f_atan(ATAN_IDX_W'(r_step))));
    end

    // Round Q4.30 to Q1.FRAC_BITS, clamp to +-1.0, undo the fold
    always_comb begin
        c_rnd = (r_x + RND) >>> (30 - FRAC_BITS);
        s_rnd = (r_y + RND) >>> (30 - FRAC_BITS);
        c_clp = c_rnd;
        s_clp = s_rnd;
        if (c_rnd > ONE)  c_clp = ONE;
        if (c_rnd < -ONE) c_clp = -ONE;
        if (s_rnd > ONE)  s_clp = ONE;
        if (s_rnd < -ONE) s_clp = -ONE;
        if (r_flip) begin
            c_clp = -c_clp;
            s_clp = -s_clp;
        end
        o_cos = TRIG_W'(c_clp);
        o_sin = TRIG_W'(s_clp);
    end

    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = (r_state == S_DONE);

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_z     <= ANG_W'(i_angle) <<< ANG_SHIFT;
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    // one full turn is enough for a Q3.12 angle
                    if (r_z > ANG_PI)
                        r_z <= r_z - ANG_TWO_PI;
                    else if (r_z < -ANG_PI)
                        r_z <= r_z + ANG_TWO_PI;
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_flip <= 1'b0;
                    if (r_z > ANG_HALF_PI) begin
                        r_z    <= r_z - ANG_PI;
                        r_flip <= 1'b1;
                    end else if (r_z < -ANG_HALF_PI) begin
                        r_z    <= r_z + ANG_PI;
                        r_flip <= 1'b1;
                    end
                    r_x     <= CORDIC_GAIN;
                    r_y     <= '0;
                    r_step  <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (!r_z[ANG_W-1]) begin
                        r_x <= r_x - sh_y;
                        r_y <= r_y + sh_x;
                        r_z <= r_z - atan_v;
                    end else begin
                        r_x <= r_x + sh_y;
                        r_y <= r_y - sh_x;
                        r_z <= r_z + atan_v;
                    end
                    if (r_step == STEP_W'(CORDIC_STEPS - 1))
                        r_state <= S_DONE;
                    else
                        r_step <= r_step + 1'b1;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `CPTW_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, r_state == S_IDLE, "rotator started while busy")
    `CPTW_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_sts.done, !o_sts.done && !o_sts.busy, "done is not a single pulse")
    `CPTW_ASSERT_NXT(a_fold_to_rot, i_clk, i_rst_n, r_state == S_FOLD, r_state == S_ROT && r_step == '0, "rotation did not start at step zero")

endmodule

// ===== rtl/core/cptw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card point transform: point pipeline
// Scale, shear, roll, pitch and yaw in eleven register stages; each multiply
// is registered before its rounding and saturation.
// ----------------------------------------------------------------------------
module cptw_datapath
    import cptw_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  t_cmd                        i_cmd,
    input  t_geom                       i_geom,
    input  logic signed [FRAC_BITS+1:0] i_roll_cos,
    input  logic signed [FRAC_BITS+1:0] i_roll_sin,
    input  logic signed [FRAC_BITS+1:0] i_pitch_cos,
    input  logic signed [FRAC_BITS+1:0] i_pitch_sin,
    input  logic signed [FRAC_BITS+1:0] i_yaw_cos,
    input  logic signed [FRAC_BITS+1:0] i_yaw_sin,
    output logic                        o_valid,
    output t_rsp                        o_rsp
);

    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    // Product back to Q16.16, rounding half up
    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] p);
        return (p + RND_HALF) >>> FRAC_BITS;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] f_sat(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (v > SAT_MAX) c = SAT_MAX;
        if (v < SAT_MIN) c = SAT_MIN;
        return DATA_W'(c);
    endfunction

    logic [PIPE_LAT-2:0] r_vld;

    logic signed [DATA_W-1:0] r1_lx, r1_ly;
    logic signed [63:0]       r2_px, r2_py;
    logic signed [DATA_W-1:0] r3_sx, r3_sy;
    logic signed [DATA_W-1:0] r4_sx, r4_sy;
    logic signed [63:0]       r4_hxp, r4_hyp;
    logic signed [DATA_W-1:0] r5_hx, r5_hy;
    logic signed [63:0]       r6_hxc, r6_hys, r6_hxs, r6_hyc;
    logic signed [DATA_W-1:0] r7_px, r7_py;
    logic signed [DATA_W-1:0] r8_px;
    logic signed [63:0]       r8_yp, r8_zp;
    logic signed [DATA_W-1:0] r9_px, r9_y1, r9_z1;
    logic signed [63:0]       r10_pxc, r10_zs, r10_zc, r10_pxs;
    logic signed [DATA_W-1:0] r10_y1;

    // Valid bits ride along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[PIPE_LAT-3:0], i_valid};
            o_valid <= r_vld[PIPE_LAT-2];
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        // capture request
        r1_lx <= i_cmd.local_x;
        r1_ly <= i_cmd.local_y;
        // per-axis scale
        r2_px <= r1_lx * i_geom.scale_x;
        r2_py <= r1_ly * i_geom.scale_y;
        r3_sx <= f_sat(f_rnd(r2_px));
        r3_sy <= f_sat(f_rnd(r2_py));
        // shear in scaled units
        r4_sx  <= r3_sx;
        r4_sy  <= r3_sy;
        r4_hxp <= r3_sy * i_geom.shear_x;
        r4_hyp <= r3_sx * i_geom.shear_y;
        r5_hx  <= f_sat(64'(r4_sx) + f_rnd(r4_hxp));
        r5_hy  <= f_sat(64'(r4_sy) + f_rnd(r4_hyp));
        // in-plane roll
        r6_hxc <= r5_hx * i_roll_cos;
        r6_hys <= r5_hy * i_roll_sin;
        r6_hxs <= r5_hx * i_roll_sin;
        r6_hyc <= r5_hy * i_roll_cos;
        r7_px  <= f_sat(f_rnd(r6_hxc) - f_rnd(r6_hys));
        r7_py  <= f_sat(f_rnd(r6_hxs) + f_rnd(r6_hyc));
        // pitch about x
        r8_px <= r7_px;
        r8_yp <= r7_py * i_pitch_cos;
        r8_zp <= r7_py * i_pitch_sin;
        r9_px <= r8_px;
        r9_y1 <= f_sat(f_rnd(r8_yp));
        r9_z1 <= f_sat(f_rnd(r8_zp));
        // yaw about y
        r10_y1  <= r9_y1;
        r10_pxc <= r9_px * i_yaw_cos;
        r10_zs  <= r9_z1 * i_yaw_sin;
        r10_zc  <= r9_z1 * i_yaw_cos;
        r10_pxs <= r9_px * i_yaw_sin;
        o_rsp.world_x <= f_sat(f_rnd(r10_pxc) + f_rnd(r10_zs));
        o_rsp.world_y <= r10_y1;
        o_rsp.world_z <= f_sat(f_rnd(r10_zc) - f_rnd(r10_pxs));
    end

endmodule

// ===== verif/card_point_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card point transform checker
// Watches the config, request and result ports of the transform unit, keeps
// its own copy of the registers and of the sine/cosine values, predicts each
// world point and compares the result stream against it in order.
// ----------------------------------------------------------------------------
module card_point_checker
    import cptw_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_cmd              i_cmd,
    input  logic              i_valid,
    input  t_rsp              i_rsp,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_wdata,
    output int                o_pending,
    output int                o_mismatches
);

    localparam int REPORT_MAX = 10;
    localparam int ATAN_ROWS  = 24;

    // Angle constants and rotator gain in Q2.30, plus the Q3.12 to Q2.30 scale
    localparam longint HALF_TURN    = 64'sd3373259426;
    localparam longint FULL_TURN    = 64'sd6746518852;
    localparam longint QUARTER_TURN = 64'sd1686629713;
    localparam longint ROTATOR_GAIN = 64'sd652032874;
    localparam longint Q30_PER_Q12  = 64'sd262144;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // arctan(2^-i) in Q2.30
    longint atan_q30 [0:ATAN_ROWS-1] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048,
        1024, 512, 256, 128
    };

    // Shadow registers and trig state
    longint gain_x, gain_y, skew_x, skew_y;
    longint cos_roll, sin_roll, cos_pitch, sin_pitch, cos_yaw, sin_yaw;

    t_rsp   expected_points [$];
    t_rsp   want;
    int     mismatches = 0;

    // Fixed-point product, rounded half up
    function automatic longint q_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    // CORDIC rotation of a Q3.12 angle to Q1.FRAC_BITS cosine and sine
    function automatic void sin_cos_of(input logic [15:0] angle,
                                       output longint cos_v, output longint sin_v);
        longint z, x, y, nx, one_q, c, s;
        bit     folded;
        z = longint'($signed(angle)) * Q30_PER_Q12;
        x = ROTATOR_GAIN;
        y = 0;
        folded = 1'b0;
        while (z > HALF_TURN) z -= FULL_TURN;
        while (z < -HALF_TURN) z += FULL_TURN;
        // fold into the right half plane, negate both at the end
        if (z > QUARTER_TURN) begin
            z -= HALF_TURN;
            folded = 1'b1;
        end else if (z < -QUARTER_TURN) begin
            z += HALF_TURN;
            folded = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_ROWS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= atan_q30[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += atan_q30[i];
            end
            x = nx;
        end
        one_q = 64'sd1 <<< FRAC_BITS;
        c = (x + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        s = (y + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (c > one_q) c = one_q;
        if (c < -one_q) c = -one_q;
        if (s > one_q) s = one_q;
        if (s < -one_q) s = -one_q;
        if (folded) begin
            c = -c;
            s = -s;
        end
        cos_v = c;
        sin_v = s;
    endfunction

    // Scale, shear, roll, pitch, yaw; every stage saturates to 32 bits
    function automatic t_rsp world_point(input t_cmd pt);
        longint sx, sy, hx, hy, px, py, y1, z1, wx, wz;
        t_rsp   r;
        sx = clamp32(q_mul(longint'($signed(pt.local_x)), gain_x));
        sy = clamp32(q_mul(longint'($signed(pt.local_y)), gain_y));
        hx = clamp32(sx + q_mul(sy, skew_x));
        hy = clamp32(sy + q_mul(sx, skew_y));
        px = clamp32(q_mul(hx, cos_roll) - q_mul(hy, sin_roll));
        py = clamp32(q_mul(hx, sin_roll) + q_mul(hy, cos_roll));
        y1 = clamp32(q_mul(py, cos_pitch));
        z1 = clamp32(q_mul(py, sin_pitch));
        wx = clamp32(q_mul(px, cos_yaw) + q_mul(z1, sin_yaw));
        wz = clamp32(q_mul(z1, cos_yaw) - q_mul(px, sin_yaw));
        r.world_x = wx[31:0];
        r.world_y = y1[31:0];
        r.world_z = wz[31:0];
        return r;
    endfunction

    // Monitor: results, then requests, then register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain_x    = 64'sd1 <<< FRAC_BITS;
            gain_y    = 64'sd1 <<< FRAC_BITS;
            skew_x    = 0;
            skew_y    = 0;
            cos_roll  = 64'sd1 <<< FRAC_BITS;
            cos_pitch = 64'sd1 <<< FRAC_BITS;
            cos_yaw   = 64'sd1 <<< FRAC_BITS;
            sin_roll  = 0;
            sin_pitch = 0;
            sin_yaw   = 0;
            expected_points.delete();
        end else begin
            if (i_valid) begin
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result with no request pending: x=%h y=%h z=%h",
                                 $time, i_rsp.world_x, i_rsp.world_y, i_rsp.world_z);
                end else begin
                    want = expected_points.pop_front();
                    if (i_rsp.world_x !== want.world_x || i_rsp.world_y !== want.world_y ||
                        i_rsp.world_z !== want.world_z) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: point mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                                     $time, want.world_x, want.world_y, want.world_z,
                                     i_rsp.world_x, i_rsp.world_y, i_rsp.world_z);
                    end
                end
            end

            if (i_start && !i_busy)
                expected_points.push_back(world_point(i_cmd));

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SCALE_X: gain_x = longint'($signed(i_cfg_wdata));
                    REG_SCALE_Y: gain_y = longint'($signed(i_cfg_wdata));
                    REG_SHEAR_X: skew_x = longint'($signed(i_cfg_wdata));
                    REG_SHEAR_Y: skew_y = longint'($signed(i_cfg_wdata));
                    REG_ROLL:    sin_cos_of(i_cfg_wdata[15:0], cos_roll, sin_roll);
                    REG_PITCH:   sin_cos_of(i_cfg_wdata[15:0], cos_pitch, sin_pitch);
                    REG_YAW:     sin_cos_of(i_cfg_wdata[15:0], cos_yaw, sin_yaw);
                    default: ;  // no register behind this index
                endcase
            end
        end
        o_pending    <= expected_points.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Card point transform testbench
// Drives point requests and register writes into the transform unit: a
// directed set of corner points and angles, then random setups with random
// points under several sender idle rates. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import cptw_pkg::*;

    localparam int     FRAC_BITS        = 16;
    localparam int     CORDIC_STEPS     = 16;
    localparam int     CLK_PERIOD       = 8;
    localparam int     RESET_CYCLES     = 12;
    localparam int     RESULT_LATENCY   = 11;
    localparam int     SETTLE_CYCLES    = RESULT_LATENCY + 4;
    localparam int     PHASES           = 10;
    localparam int     POINTS_PER_PHASE = 75;
    localparam longint RUN_LIMIT_NS     = 2000000;

    // Index past the last register; the unit must ignore it
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_HALF = 32'h0000_8000;
    localparam logic [DATA_W-1:0] Q_NEG1 = 32'hFFFF_FFFF;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_cmd              i_cmd       = '0;
    logic              o_valid;
    t_rsp              o_rsp;
    logic              i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx   = '0;
    logic [DATA_W-1:0] i_cfg_wdata = '0;

    int idle_pct = 0;
    int idle_plan [0:2] = '{0, 45, 16};
    int pending_points;
    int mismatch_count;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    card_point_to_world_transform_unit #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    card_point_checker #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) point_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_valid      (o_valid),
        .i_rsp        (o_rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending_points),
        .o_mismatches (mismatch_count)
    );

    // One register write; the write enable is dropped again before the task returns
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Request one point; start stays high across back-to-back requests.
    // Each cycle before the request is idle with probability idle_pct percent.
    task automatic send_point(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y);
        int   gap;
        t_cmd pt;
        gap = 0;
        while (int'($urandom_range(0, 99)) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt.local_x = x;
        pt.local_y = y;
        start <= 1'b1;
        i_cmd <= pt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Let every outstanding point come back before touching registers
    task automatic settle();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_points != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_edge();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 32'h1;
            2:       return Q_NEG1;
            3:       return Q_MAX;
            default: return Q_MIN;
        endcase
    endfunction

    // Mostly values within +-half_range, some full-range values, some zero, +-1 LSB or rail values
    function automatic logic [DATA_W-1:0] rand_factor(input int half_range);
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return pick_edge();
            default: return 32'($urandom_range(0, 2 * half_range) - half_range);
        endcase
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset trig: exact unit cosines and zero sines
        send_point('0, '0);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(32'h1, Q_NEG1);
        send_point(Q_ONE, 32'h0002_0000);
        send_point(Q_MAX, Q_MIN);
        settle();

        // scale at the rails, shear at +-one half: overflow in the early stages
        write_reg(REG_SCALE_X, Q_MAX);
        write_reg(REG_SCALE_Y, Q_MIN);
        write_reg(REG_SHEAR_X, Q_HALF);
        write_reg(REG_SHEAR_Y, 32'hFFFF_8000);
        send_point(Q_ONE, Q_ONE);
        send_point(Q_NEG1, Q_NEG1);
        send_point(Q_HALF, 32'hFFFF_8000);
        send_point(Q_MIN, Q_MAX);
        settle();

        // zero angle through the rotator, full-scale angles that wrap,
        // and a write to the spare index
        write_reg(REG_SCALE_X, Q_ONE);
        write_reg(REG_SCALE_Y, 32'h0000_C000);
        write_reg(REG_ROLL, '0);
        write_reg(REG_PITCH, 32'h0000_7FFF);
        write_reg(REG_YAW, 32'hFFFF_8000);
        write_reg(REG_SPARE, $urandom);
        send_point(Q_ONE, '0);
        send_point('0, Q_ONE);
        send_point(32'h0064_0000, 32'hFF9C_0000);
        send_point(Q_MAX, Q_MAX);
        settle();

        // just past a half turn both ways, just past a quarter turn;
        // shear at the rails drives the later stages into saturation
        write_reg(REG_ROLL, 32'd12868);
        write_reg(REG_PITCH, 32'd6434);
        write_reg(REG_YAW, 32'hFFFF_CDBC);
        write_reg(REG_SHEAR_X, Q_MAX);
        write_reg(REG_SHEAR_Y, Q_MIN);
        send_point(Q_ONE, Q_ONE);
        send_point(32'h0000_0100, 32'hFFFF_FF00);
        send_point(Q_MIN, '0);
        send_point('0, Q_MIN);
        settle();

        // random setups, each followed by a stream of random points
        for (int phase = 0; phase < PHASES; phase++) begin
            idle_pct = idle_plan[phase % 3];
            write_reg(REG_SCALE_X, rand_factor(1 << 18));
            write_reg(REG_SCALE_Y, rand_factor(1 << 18));
            write_reg(REG_SHEAR_X, ($urandom_range(0, 3) == 0) ? '0 : rand_factor(1 << 16));
            write_reg(REG_SHEAR_Y, ($urandom_range(0, 3) == 0) ? '0 : rand_factor(1 << 16));
            // angles sometimes kept from the previous setup
            if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(REG_ROLL, $urandom);
            if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(REG_PITCH, $urandom);
            if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(REG_YAW, $urandom);
            if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
            for (int n = 0; n < POINTS_PER_PHASE; n++)
                send_point(rand_factor(1 << 24), rand_factor(1 << 24));
            settle();
        end

        if (mismatch_count == 0 && pending_points == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
